FILE: hw/rtl/fraction_arithmetic_reducer_top_assert.svh
// Assertion macros for the fraction reducer.
`ifndef FRACTION_ARITHMETIC_REDUCER_TOP_ASSERT_SVH
`define FRACTION_ARITHMETIC_REDUCER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define FAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FAR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FAR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/far_pkg.sv
// Shared types and constants of the fraction reducer.
package far_pkg;
	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int MAG_W = 64;
	localparam int LANES = 4;
	localparam int CNT_W = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_RED,
		ST_OUT
	} far_state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
		logic undef;
	} lane_stat_t;
endpackage

FILE: hw/rtl/far_in_if.sv
// Input channel of the fraction reducer.
interface far_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] num_a;
	logic signed [15:0] den_a;
	logic signed [15:0] num_b;
	logic signed [15:0] den_b;
	modport source (output valid, num_a, den_a, num_b, den_b, input ready);
	modport sink (input valid, num_a, den_a, num_b, den_b, output ready);
endinterface

FILE: hw/rtl/far_out_if.sv
// Output channel of the fraction reducer.
interface far_out_if;
	logic valid;
	logic ready;
	logic signed [32:0] sum_num;
	logic signed [31:0] sum_den;
	logic signed [32:0] diff_num;
	logic signed [31:0] diff_den;
	logic signed [31:0] prod_num;
	logic signed [31:0] prod_den;
	logic signed [31:0] quot_num;
	logic signed [31:0] quot_den;
	logic [3:0] undefined_mask;
	modport source (output valid, sum_num, sum_den, diff_num, diff_den, prod_num, prod_den,
		quot_num, quot_den, undefined_mask, input ready);
	modport sink (input valid, sum_num, sum_den, diff_num, diff_den, prod_num, prod_den,
		quot_num, quot_den, undefined_mask, output ready);
endinterface

FILE: hw/rtl/fraction_arithmetic_reducer_top.sv
// Top level of the fraction reducer.
// One item at a time: a multiply stage forms the four unreduced pairs, then four lanes run a
// binary gcd and a restoring division (one step per value bit, 34 steps at the default
// operand width) side by side. In the gcd each subtraction is followed by at least one
// halving. An item is done when the slowest lane's gcd and division are done, and its
// output transfer can then stall until out_ch.ready.
module fraction_arithmetic_reducer_top #(
	parameter int OPERAND_WIDTH = far_pkg::OPERAND_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	far_in_if.sink  in_ch,
	far_out_if.source out_ch
);
	import far_pkg::*;

	localparam int VW = 2 * OPERAND_WIDTH + 2;
	`include "fraction_arithmetic_reducer_top_assert.svh"

	far_state_t st_q, st_nxt;
	logic signed [OPERAND_WIDTH-1:0] a_q, b_q, c_q, d_q;
	logic signed [VW-1:0] num_s1 [LANES], den_s1 [LANES];
	logic signed [VW-1:0] num_r [LANES], den_r [LANES];
	lane_stat_t lst [LANES];
	logic [LANES-1:0] done_v, busy_v, undef_v;
	logic signed [2*OPERAND_WIDTH-1:0] ad, cb, ac, bd;
	logic go;

	// Hold operands
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			a_q <= OPERAND_WIDTH'($unsigned(in_ch.num_a));
			b_q <= OPERAND_WIDTH'($unsigned(in_ch.den_a));
			c_q <= OPERAND_WIDTH'($unsigned(in_ch.num_b));
			d_q <= OPERAND_WIDTH'($unsigned(in_ch.den_b));
		end
	end

	assign ad = a_q * d_q;
	assign cb = c_q * b_q;
	assign ac = a_q * c_q;
	assign bd = b_q * d_q;

	// Register the unreduced pairs
	always_ff @(posedge clk) begin
		if (st_q == ST_MUL) begin
			num_s1[0] <= VW'(ad) + VW'(cb);
			num_s1[1] <= VW'(ad) - VW'(cb);
			num_s1[2] <= VW'(ac);
			num_s1[3] <= VW'(ad);
			den_s1[0] <= VW'(bd);
			den_s1[1] <= VW'(bd);
			den_s1[2] <= VW'(bd);
			den_s1[3] <= VW'(cb);
		end
	end

	logic mul_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mul_q <= 1'b0;
		else mul_q <= (st_q == ST_MUL);
	end
	assign go = mul_q;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		far_lane #(.VAL_W(VW)) u_lane (
			.clk(clk), .arst_n(arst_n), .start(go),
			.num(num_s1[i]), .den(den_s1[i]),
			.stat(lst[i]), .num_r(num_r[i]), .den_r(den_r[i])
		);
		assign done_v[i] = lst[i].busy && !lst[i].done ? 1'b0 : 1'b1;
		assign busy_v[i] = lst[i].busy;
		assign undef_v[i] = lst[i].undef;
	end

	// Advance control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_nxt;
	end

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: if (in_ch.valid) st_nxt = ST_MUL;
			ST_MUL: st_nxt = ST_RED;
			ST_RED: if (!go && busy_v == '0) st_nxt = ST_OUT;
			ST_OUT: if (out_ch.ready) st_nxt = ST_IDLE;
			default: st_nxt = ST_IDLE;
		endcase
	end

	// Merge lane results into the output transfer
	always_comb begin
		in_ch.ready = (st_q == ST_IDLE);
		out_ch.valid = (st_q == ST_OUT);
		out_ch.sum_num = 33'(num_r[0]);
		out_ch.sum_den = 32'(den_r[0]);
		out_ch.diff_num = 33'(num_r[1]);
		out_ch.diff_den = 32'(den_r[1]);
		out_ch.prod_num = 32'(num_r[2]);
		out_ch.prod_den = 32'(den_r[2]);
		out_ch.quot_num = 32'(num_r[3]);
		out_ch.quot_den = 32'(den_r[3]);
		out_ch.undefined_mask = undef_v;
	end

	`FAR_ASSERT_IMP(a_out_idle, clk, arst_n, out_ch.valid, busy_v == '0)
	`FAR_ASSERT_IMP(a_excl, clk, arst_n, in_ch.ready, !out_ch.valid)
	`FAR_ASSERT_NXT(a_start, clk, arst_n, go, busy_v == '1 && done_v == '0)
endmodule

FILE: hw/rtl/far_lane.sv
// One reduction lane: binary gcd, then exact division by restoring steps.
module far_lane #(
	parameter int VAL_W = 34
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [VAL_W-1:0] num,
	input  logic signed [VAL_W-1:0] den,
	output far_pkg::lane_stat_t     stat,
	output logic signed [VAL_W-1:0] num_r,
	output logic signed [VAL_W-1:0] den_r
);
	import far_pkg::*;

	localparam int SH_W = $clog2(VAL_W + 1);

	typedef enum logic [2:0] {
		L_IDLE,
		L_STRIP,
		L_GCD,
		L_DIV,
		L_DONE
	} lane_st_t;

	lane_st_t st_q;
	logic [VAL_W-1:0] x_q, y_q, g_q;
	logic [SH_W-1:0] k_q;
	logic [VAL_W-1:0] an_q, ad_q, qn_q, qd_q, rn_q, rd_q;
	logic sn_q, sd_q, undef_q;
	logic [SH_W-1:0] bit_q;
	logic [VAL_W-1:0] mn, md, dif;
	logic [VAL_W:0] tn, td;

	// Take magnitudes of both parts
	assign mn = num[VAL_W-1] ? VAL_W'(-num) : VAL_W'(num);
	assign md = den[VAL_W-1] ? VAL_W'(-den) : VAL_W'(den);
	assign dif = (x_q > y_q) ? (x_q - y_q) : (y_q - x_q);

	// Restoring division trial for both parts against g
	assign tn = {rn_q, an_q[VAL_W-1]} - {1'b0, g_q};
	assign td = {rd_q, ad_q[VAL_W-1]} - {1'b0, g_q};

	// Sequence gcd and division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			undef_q <= 1'b0;
		end else begin
			case (st_q)
				L_IDLE: begin
					if (start) begin
						an_q <= mn;
						ad_q <= md;
						sn_q <= num[VAL_W-1];
						sd_q <= den[VAL_W-1];
						x_q <= mn;
						y_q <= md;
						k_q <= '0;
						undef_q <= (mn == '0) && (md == '0);
						st_q <= (mn == '0 || md == '0) ? L_GCD : L_STRIP;
					end
				end
				L_STRIP: begin
					if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + 1'b1;
					end else begin
						st_q <= L_GCD;
					end
				end
				L_GCD: begin
					if (x_q == '0 || y_q == '0) begin
						g_q <= (x_q | y_q) << k_q;
						rn_q <= '0;
						rd_q <= '0;
						bit_q <= '0;
						st_q <= (x_q == '0 && y_q == '0) ? L_DONE : L_DIV;
						qn_q <= '0;
						qd_q <= '0;
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q > y_q) begin
						x_q <= dif;
					end else begin
						y_q <= dif;
					end
				end
				L_DIV: begin
					if (!tn[VAL_W]) rn_q <= tn[VAL_W-1:0];
					else rn_q <= {rn_q[VAL_W-2:0], an_q[VAL_W-1]};
					if (!td[VAL_W]) rd_q <= td[VAL_W-1:0];
					else rd_q <= {rd_q[VAL_W-2:0], ad_q[VAL_W-1]};
					qn_q <= {qn_q[VAL_W-2:0], ~tn[VAL_W]};
					qd_q <= {qd_q[VAL_W-2:0], ~td[VAL_W]};
					an_q <= an_q << 1;
					ad_q <= ad_q << 1;
					bit_q <= bit_q + 1'b1;
					if (bit_q == SH_W'(VAL_W - 1)) st_q <= L_DONE;
				end
				L_DONE: st_q <= L_IDLE;
				default: st_q <= L_IDLE;
			endcase
		end
	end

	// Restore signs; an undefined pair gives 0/0
	assign num_r = sn_q ? -$signed(qn_q) : $signed(qn_q);
	assign den_r = sd_q ? -$signed(qd_q) : $signed(qd_q);
	assign stat.start = start;
	assign stat.busy = (st_q != L_IDLE);
	assign stat.done = (st_q == L_DONE);
	assign stat.undef = undef_q;
endmodule
